@@ src/iomst_pkg.sv @@
package iomst_pkg;

    typedef enum logic [2:0] {
        ST_MAPPED    = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic {
        CMD_CREATE  = 1'b0,
        CMD_DESTROY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [63:0] virt;
        t_status     status;
    } t_result;

    localparam logic [63:0] PTR_RESET = 64'hFFFF_8000_0000_0000;
    localparam logic [63:0] PAGE_MASK = 64'h0000_0000_0000_0FFF;

endpackage

@@ src/io_mapping_slot_table_unit.sv @@
// Mapping slot table with a bump allocator for virtual addresses. Each input
// beat is a create or a destroy command and yields exactly one result beat.
// A create takes the lowest free slot by walking the valid bits one slot per
// cycle; a destroy reads the slot memory one entry per cycle through its
// registered read port and compares each entry. A zero-size create or a null
// destroy finishes without a scan. The result then moves into the output
// register. A new command is taken while an earlier result still waits on the
// output.
module io_mapping_slot_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_region_bytes,
    input  logic [63:0] i_target_virt,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_mapped_virt,
    output logic [2:0]  o_status
);

    import iomst_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    logic          r_out_valid;
    t_result       r_out;

    iomst_scan #(
        .SLOTS(SLOTS),
        .AW   (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_region_bytes(i_region_bytes),
        .i_target_virt (i_target_virt),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

    iomst_slot_ram #(
        .DEPTH(SLOTS),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mapped_virt = r_out.virt;
    assign o_status      = r_out.status;

endmodule

@@ src/iomst_slot_ram.sv @@
module iomst_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/iomst_scan.sv @@
module iomst_scan #(
    parameter int SLOTS = 16,
    parameter int AW    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [31:0]        i_region_bytes,
    input  logic [63:0]        i_target_virt,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output iomst_pkg::t_result o_res,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [63:0]        o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [63:0]        i_ram_rdata
);

    import iomst_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);
    localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state;
    logic             r_cmd;
    logic [31:0]      r_bytes;
    logic [63:0]      r_target;
    logic [63:0]      r_ptr;
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0]    r_idx;
    logic             r_cmp_vld;
    logic [AW-1:0]    r_cmp_idx;
    t_result          r_res;

    logic [AW-1:0] idx_a;
    logic          free_here;
    logic          hit;
    logic [63:0]   n_ptr;

    assign idx_a     = r_idx[AW-1:0];
    assign free_here = !r_valid[idx_a];
    assign hit       = r_cmp_vld && r_valid[r_cmp_idx] && (i_ram_rdata == r_target);
    // Advance by the size, then round up to the next 4 KiB page.
    assign n_ptr     = (r_ptr + {32'd0, r_bytes} + PAGE_MASK) & ~PAGE_MASK;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign o_ram_we    = (r_state == S_SCAN) && (r_cmd == CMD_CREATE) && free_here;
    assign o_ram_waddr = idx_a;
    assign o_ram_wdata = r_ptr;
    assign o_ram_raddr = idx_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= PTR_RESET;
            r_valid   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_cmd;
                        r_bytes   <= i_region_bytes;
                        r_target  <= i_target_virt;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        if (i_cmd == CMD_CREATE && i_region_bytes == 32'd0) begin
                            r_res   <= '{virt: 64'd0, status: ST_ZERO_SIZE};
                            r_state <= S_DONE;
                        end else if (i_cmd == CMD_DESTROY && i_target_virt == 64'd0) begin
                            r_res   <= '{virt: 64'd0, status: ST_NOT_FOUND};
                            r_state <= S_DONE;
                        end else begin
                            r_res   <= '{virt: 64'd0, status: ST_NOT_FOUND};
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cmd == CMD_CREATE) begin
                        // Walk the valid bits until the lowest free slot turns up or the last slot is checked.
                        if (free_here) begin
                            r_valid[idx_a] <= 1'b1;
                            r_ptr          <= n_ptr;
                            r_res          <= '{virt: r_ptr, status: ST_MAPPED};
                            r_state        <= S_DONE;
                        end else if (r_idx == CNT_LAST) begin
                            r_res.status <= ST_FULL;
                            r_state      <= S_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        // One read issued per cycle; its data is compared in the next cycle.
                        if (r_idx != CNT_END) begin
                            r_idx     <= r_idx + 1'b1;
                            r_cmp_vld <= 1'b1;
                            r_cmp_idx <= idx_a;
                        end else begin
                            r_cmp_vld <= 1'b0;
                        end
                        if (hit) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                            r_res.status       <= ST_FREED;
                            r_state            <= S_DONE;
                        end else if (r_cmp_vld && r_cmp_idx == IDX_LAST) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_cmp_vld <= 1'b0;
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
